[hw/rtl/tabular_q_learning_engine_defines.svh]
// ----------------------------------------------------------------------------
// Tabular Q-learning engine: assertion macros
// Shared property wrappers, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TABULAR_Q_LEARNING_ENGINE_DEFINES_SVH
`define TABULAR_Q_LEARNING_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define TQLE_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TQLE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tqle_pkg.sv]
// ----------------------------------------------------------------------------
// tqle_pkg
// Constants, types and helper functions shared by the Q-learning engine.
// ----------------------------------------------------------------------------
package tqle_pkg;

    // Table geometry
    localparam int NUM_ACTIONS = 4;
    localparam int GRID_WIDTH  = 16;
    localparam int GRID_HEIGHT = 16;
    localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
    localparam int CELL_W      = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int LANE_W      = $clog2(NUM_ACTIONS);
    localparam int TIE_W       = $clog2(NUM_ACTIONS + 1);

    // Field widths
    localparam int COORD_W = 4;
    localparam int ACT_W   = 2;
    localparam int VAL_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int ROW_W   = NUM_ACTIONS * VAL_W;

    // Arithmetic widths
    localparam int GM_W  = 2 * VAL_W + 1;    // discount * max
    localparam int TD_W  = 2 * VAL_W + 3;    // td in Q.16
    localparam int TL_W  = 17;               // low slice of td
    localparam int TH_W  = TD_W - TL_W;      // high slice of td
    localparam int LO_W  = FRAC_W + TL_W;
    localparam int HI_W  = FRAC_W + 1 + TH_W;
    localparam int ACC_W = 53;               // old * 2^32 + lr * td
    localparam int Q_W   = ACC_W - 2 * FRAC_W;

    // Tie breaker
    localparam int               LFSR_W     = 16;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam int               DIGIT_W    = 4;
    localparam int               MOD_STEPS  = LFSR_W / DIGIT_W;
    localparam int               MOD_STEP_W = $clog2(MOD_STEPS);
    localparam int               CNT_W      = (LANE_W > MOD_STEP_W) ? LANE_W : MOD_STEP_W;

    // Configuration registers
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0]  CFG_DISCOUNT       = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_LEARN_RATE     = 1'd1;
    localparam logic [CFG_DATA_W-1:0] DISCOUNT_RESET     = 16'd58982;
    localparam logic [CFG_DATA_W-1:0] LEARN_RATE_RESET   = 16'd6554;

    // Command codes
    localparam logic CMD_CHOOSE = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef struct packed {
        logic                      command;
        logic [COORD_W-1:0]        cell_x;
        logic [COORD_W-1:0]        cell_y;
        logic [ACT_W-1:0]          taken_action;
        logic [COORD_W-1:0]        next_x;
        logic [COORD_W-1:0]        next_y;
        logic signed [VAL_W-1:0]   reward;
    } req_t;

    typedef struct packed {
        logic [ACT_W-1:0]          chosen_action;
        logic signed [VAL_W-1:0]   old_value;
    } res_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD_CUR,
        OP_LATCH_CUR,
        OP_RD_NXT,
        OP_LATCH_NXT,
        OP_SCAN,
        OP_MOD,
        OP_PICK,
        OP_MUL1,
        OP_TD,
        OP_MUL2,
        OP_MUL3,
        OP_WB,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [LANE_W-1:0]   lane;
        logic                first;
    } dp_cmd_t;

    typedef struct packed {
        logic is_update;
        logic act_ok;
        logic out_busy;
    } dp_stat_t;

    // Row address of a grid cell, coordinates clamped to the grid
    function automatic logic [CELL_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y);
        int unsigned cx;
        int unsigned cy;
        cx = 32'(x);
        cy = 32'(y);
        if (cx >= GRID_WIDTH)
        begin
            cx = GRID_WIDTH - 1;
        end
        if (cy >= GRID_HEIGHT)
        begin
            cy = GRID_HEIGHT - 1;
        end
        return CELL_W'(cx * GRID_HEIGHT + cy);
    endfunction

    // Fibonacci LFSR, taps 16,14,13,11
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] l);
        logic fb;
        fb = l[0] ^ l[2] ^ l[3] ^ l[5];
        return {fb, l[LFSR_W-1:1]};
    endfunction

endpackage

[hw/rtl/tqle_req_if.sv]
// ----------------------------------------------------------------------------
// tqle_req_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface tqle_req_if import tqle_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [COORD_W-1:0]      cell_x;
    logic [COORD_W-1:0]      cell_y;
    logic [ACT_W-1:0]        taken_action;
    logic [COORD_W-1:0]      next_x;
    logic [COORD_W-1:0]      next_y;
    logic signed [VAL_W-1:0] reward;

    modport source (
        output valid, command, cell_x, cell_y, taken_action, next_x, next_y, reward,
        input  ready
    );

    modport sink (
        input  valid, command, cell_x, cell_y, taken_action, next_x, next_y, reward,
        output ready
    );

endinterface

[hw/rtl/tqle_res_if.sv]
// ----------------------------------------------------------------------------
// tqle_res_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface tqle_res_if import tqle_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        chosen_action;
    logic signed [VAL_W-1:0] old_value;

    modport source (
        output valid, chosen_action, old_value,
        input  ready
    );

    modport sink (
        input  valid, chosen_action, old_value,
        output ready
    );

endinterface

[hw/rtl/tqle_ctrl.sv]
// ----------------------------------------------------------------------------
// tqle_ctrl
// Command sequencer: walks each transaction through read, scan, tie pick or
// update arithmetic, write-back and result hand-off.
// ----------------------------------------------------------------------------
module tqle_ctrl import tqle_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_CUR,
        S_LATCH_CUR,
        S_RD_NXT,
        S_LATCH_NXT,
        S_SCAN,
        S_MOD,
        S_PICK,
        S_MUL1,
        S_TD,
        S_MUL2,
        S_MUL3,
        S_WB,
        S_DONE
    } state_t;

    localparam logic [CNT_W-1:0] LANE_LAST = CNT_W'(NUM_ACTIONS - 1);
    localparam logic [CNT_W-1:0] MOD_LAST  = CNT_W'(MOD_STEPS - 1);

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              ready_reg;
    logic              ready_next;

    assign req_ready = ready_reg;

    // Next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ready_next = ready_reg;
        cmd.op     = OP_NONE;
        cmd.lane   = cnt_reg[LANE_W-1:0];
        cmd.first  = (cnt_reg == '0);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && ready_reg)
                begin
                    cmd.op     = OP_LOAD;
                    ready_next = 1'b0;
                    state_next = S_RD_CUR;
                end
            end
            S_RD_CUR:
            begin
                cmd.op     = OP_RD_CUR;
                state_next = S_LATCH_CUR;
            end
            S_LATCH_CUR:
            begin
                cmd.op   = OP_LATCH_CUR;
                cnt_next = '0;
                if (!stat.is_update)
                begin
                    state_next = S_SCAN;
                end
                else if (stat.act_ok)
                begin
                    state_next = S_RD_NXT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RD_NXT:
            begin
                cmd.op     = OP_RD_NXT;
                state_next = S_LATCH_NXT;
            end
            S_LATCH_NXT:
            begin
                cmd.op     = OP_LATCH_NXT;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (cnt_reg == LANE_LAST)
                begin
                    cnt_next   = '0;
                    state_next = stat.is_update ? S_MUL1 : S_MOD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MOD:
            begin
                cmd.op = OP_MOD;
                if (cnt_reg == MOD_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_PICK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_PICK:
            begin
                cmd.op = OP_PICK;
                if (cnt_reg == LANE_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = S_TD;
            end
            S_TD:
            begin
                cmd.op     = OP_TD;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.op     = OP_MUL2;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.op     = OP_MUL3;
                state_next = S_WB;
            end
            S_WB:
            begin
                cmd.op     = OP_WB;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hand result over once the output register is free
                if (!stat.out_busy)
                begin
                    cmd.op     = OP_OUT;
                    ready_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ready_reg <= ready_next;
        end
    end

endmodule

[hw/rtl/tqle_datapath.sv]
// ----------------------------------------------------------------------------
// tqle_datapath
// Value table memory, lane scan, tie remainder unit, update arithmetic,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module tqle_datapath import tqle_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  req_t                  req,
    input  logic                  res_ready,
    output logic                  res_valid,
    output res_t                  res,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Latched command and addresses
    req_t                     req_reg;
    logic [CELL_W-1:0]        cur_addr_reg;
    logic [CELL_W-1:0]        nxt_addr_reg;

    // Table: one row of action values per cell, row valid bits stand for reset
    logic [ROW_W-1:0]         mem [CELLS];
    logic [CELLS-1:0]         row_valid_reg;
    logic [ROW_W-1:0]         rd_data_reg;
    logic                     rd_valid_reg;
    logic [CELL_W-1:0]        rd_addr;
    logic [ROW_W-1:0]         rd_row;

    // Scan and tie pick
    logic [ROW_W-1:0]         scan_row_reg;
    logic [ROW_W-1:0]         cur_row_reg;
    logic signed [VAL_W-1:0]  old_reg;
    logic signed [VAL_W-1:0]  max_reg;
    logic [TIE_W-1:0]         ties_reg;
    logic [TIE_W-1:0]         rem_reg;
    logic                     found_reg;
    logic [LANE_W-1:0]        chosen_reg;
    logic [LFSR_W-1:0]        mod_sh_reg;
    logic [LFSR_W-1:0]        lfsr_reg;

    // Configuration
    logic [CFG_DATA_W-1:0]    discount_reg;
    logic [CFG_DATA_W-1:0]    learn_rate_reg;

    // Update arithmetic
    logic signed [VAL_W:0]    diff_reg;
    logic signed [GM_W-1:0]   gm_reg;
    logic signed [TD_W-1:0]   td_reg;
    logic [ACC_W-1:0]         acc_reg;

    logic                     res_valid_reg;
    res_t                     res_reg;

    logic [LANE_W-1:0]        a_lane;
    logic                     act_ok;
    logic                     is_update;
    logic signed [VAL_W-1:0]  scan_val;
    logic signed [VAL_W-1:0]  rd_old;
    logic [LFSR_W-1:0]        mod_src;
    logic [DIGIT_W-1:0]       digit;
    logic [TIE_W:0]           mod_t;
    logic [TIE_W-1:0]         mod_rem;
    logic signed [GM_W-1:0]   gm_prod;
    logic signed [TD_W-1:0]   td_sum;
    logic [LO_W-1:0]          lo_prod;
    logic signed [HI_W-1:0]   hi_prod;
    logic [ACC_W-1:0]         acc_base;
    logic [ACC_W-1:0]         hi_term;
    logic [Q_W-1:0]           q_adj;
    logic                     round_up;
    logic signed [VAL_W-1:0]  new_val;
    logic [ROW_W-1:0]         new_row;

    // Status and decoding
    assign a_lane    = LANE_W'(req_reg.taken_action);
    assign act_ok    = (32'(req_reg.taken_action) < NUM_ACTIONS);
    assign is_update = (req_reg.command == CMD_UPDATE);

    assign stat.is_update = is_update;
    assign stat.act_ok    = act_ok;
    assign stat.out_busy  = res_valid_reg && !res_ready;

    assign rd_addr  = (cmd.op == OP_RD_NXT) ? nxt_addr_reg : cur_addr_reg;
    assign rd_row   = rd_valid_reg ? rd_data_reg : '0;
    assign scan_val = $signed(scan_row_reg[cmd.lane * VAL_W +: VAL_W]);
    assign rd_old   = $signed(rd_row[a_lane * VAL_W +: VAL_W]);

    // Tie remainder: lfsr mod ties, one digit per step, MSB first
    always_comb
    begin
        mod_src = cmd.first ? lfsr_reg : mod_sh_reg;
        digit   = mod_src[LFSR_W-1 -: DIGIT_W];
        mod_rem = cmd.first ? '0 : rem_reg;
        mod_t   = '0;
        for (int i = DIGIT_W - 1; i >= 0; i--)
        begin
            mod_t = {mod_rem, digit[i]};
            if (mod_t >= {1'b0, ties_reg})
            begin
                mod_t = mod_t - {1'b0, ties_reg};
            end
            mod_rem = mod_t[TIE_W-1:0];
        end
    end

    // Update arithmetic terms
    assign gm_prod  = $signed({1'b0, discount_reg}) * max_reg;
    assign td_sum   = $signed({{(TD_W - VAL_W - 1 - FRAC_W){diff_reg[VAL_W]}},
                               diff_reg, {FRAC_W{1'b0}}})
                    + $signed({{(TD_W - GM_W){gm_reg[GM_W-1]}}, gm_reg});
    assign lo_prod  = learn_rate_reg * td_reg[TL_W-1:0];
    assign hi_prod  = $signed({1'b0, learn_rate_reg}) * $signed(td_reg[TD_W-1:TL_W]);
    assign acc_base = {{(ACC_W - VAL_W - 2 * FRAC_W){old_reg[VAL_W-1]}}, old_reg,
                       {(2 * FRAC_W){1'b0}}};
    assign hi_term  = {{(ACC_W - HI_W - TL_W){hi_prod[HI_W-1]}}, hi_prod, {TL_W{1'b0}}};

    // Truncate toward zero, then saturate to 16 bits
    assign round_up = acc_reg[ACC_W-1] && (|acc_reg[2*FRAC_W-1:0]);
    assign q_adj    = acc_reg[ACC_W-1:2*FRAC_W] + Q_W'(round_up);

    always_comb
    begin
        if (q_adj[Q_W-1:VAL_W-1] == '0 || q_adj[Q_W-1:VAL_W-1] == '1)
        begin
            new_val = $signed(q_adj[VAL_W-1:0]);
        end
        else if (q_adj[Q_W-1])
        begin
            new_val = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            new_val = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        new_row = cur_row_reg;
        new_row[a_lane * VAL_W +: VAL_W] = new_val;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discount_reg   <= DISCOUNT_RESET;
            learn_rate_reg <= LEARN_RATE_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_DISCOUNT:   discount_reg   <= cfg_data;
                CFG_LEARN_RATE: learn_rate_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Tie LFSR, advanced once per choose
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= LFSR_SEED;
        end
        else if (cmd.op == OP_LATCH_CUR && !is_update)
        begin
            lfsr_reg <= lfsr_step(lfsr_reg);
        end
    end

    // Row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (cmd.op == OP_WB)
        begin
            row_valid_reg[cur_addr_reg] <= 1'b1;
        end
    end

    // Table write
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_WB)
        begin
            mem[cur_addr_reg] <= new_row;
        end
    end

    // Table read, registered
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_RD_CUR || cmd.op == OP_RD_NXT)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                req_reg      <= req;
                cur_addr_reg <= cell_addr(req.cell_x, req.cell_y);
                nxt_addr_reg <= cell_addr(req.next_x, req.next_y);
            end
            OP_LATCH_CUR:
            begin
                scan_row_reg <= rd_row;
                cur_row_reg  <= rd_row;
                old_reg      <= rd_old;
            end
            OP_LATCH_NXT:
            begin
                scan_row_reg <= rd_row;
            end
            OP_SCAN:
            begin
                if (cmd.first || scan_val > max_reg)
                begin
                    max_reg  <= scan_val;
                    ties_reg <= TIE_W'(1);
                end
                else if (scan_val == max_reg)
                begin
                    ties_reg <= ties_reg + 1'b1;
                end
            end
            OP_MOD:
            begin
                rem_reg    <= mod_rem;
                mod_sh_reg <= mod_src << DIGIT_W;
                found_reg  <= 1'b0;
            end
            OP_PICK:
            begin
                // take the tied lane at position rem in lane order
                if (scan_val == max_reg)
                begin
                    if (rem_reg == '0 && !found_reg)
                    begin
                        chosen_reg <= cmd.lane;
                        found_reg  <= 1'b1;
                    end
                    if (rem_reg != '0)
                    begin
                        rem_reg <= rem_reg - 1'b1;
                    end
                end
            end
            OP_MUL1:
            begin
                gm_reg   <= gm_prod;
                diff_reg <= {req_reg.reward[VAL_W-1], req_reg.reward}
                          - {old_reg[VAL_W-1], old_reg};
            end
            OP_TD:
            begin
                td_reg <= td_sum;
            end
            OP_MUL2:
            begin
                acc_reg <= acc_base + ACC_W'(lo_prod);
            end
            OP_MUL3:
            begin
                acc_reg <= acc_reg + hi_term;
            end
            default:
            begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_OUT)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT)
        begin
            res_reg.chosen_action <= is_update ? '0 : ACT_W'(chosen_reg);
            res_reg.old_value     <= (is_update && act_ok) ? old_reg : '0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[hw/rtl/tabular_q_learning_engine.sv]
// ----------------------------------------------------------------------------
// tabular_q_learning_engine
// Top level: command and result channels, configuration port, controller and
// datapath.
// ----------------------------------------------------------------------------
// Keeps one signed 16-bit value per grid cell and action in a single-port
// table of one row per cell; rows read as zero until first written, so no
// clearing pass is needed after reset. One transaction is in work at a time.
// A choose transaction does one row read, a scan of one action per cycle for
// the maximum and tie count, the tie remainder at four LFSR bits per cycle,
// and a second per-action scan for the pick. An update does two row reads,
// the per-action maximum scan of the next cell, the discount multiply, the
// TD sum, the low and high learn-rate multiplies, a write-back and the
// hand-off. An update with an action outside the table returns after the
// first row read, with no write-back. The result sits in an output register,
// so a finished result waiting on the sink does not block the next command
// from being taken. discount and learn_rate are Q0.16; the user must
// write them only while the engine is idle; the block does not enforce it.
`include "tabular_q_learning_engine_defines.svh"

module tabular_q_learning_engine import tqle_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    tqle_req_if.sink              request,
    tqle_res_if.source            response,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    req_t     req;
    res_t     res;
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    logic     res_valid;
    logic     req_ready;

    // Command payload into a struct
    assign req.command      = request.command;
    assign req.cell_x       = request.cell_x;
    assign req.cell_y       = request.cell_y;
    assign req.taken_action = request.taken_action;
    assign req.next_x       = request.next_x;
    assign req.next_y       = request.next_y;
    assign req.reward       = request.reward;
    assign request.ready    = req_ready;

    // Result channel
    assign response.valid         = res_valid;
    assign response.chosen_action = res.chosen_action;
    assign response.old_value     = res.old_value;

    tqle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (req_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    tqle_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .req          (req),
        .res_ready    (response.ready),
        .res_valid    (res_valid),
        .res          (res),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Only one transaction in work: ready drops after an accept
    `TQLE_ASSERT_NEXT(a_single_in_flight, request.valid && request.ready, !request.ready, "ready held after accept")

    // A result is loaded only when the output register is free
    `TQLE_ASSERT_SAME(a_no_overwrite, dp_cmd.op == OP_OUT, !(response.valid && !response.ready), "result overwritten")

    // Result valid rises only after a hand-off from the controller
    `TQLE_ASSERT_SAME(a_valid_source, $rose(response.valid), $past(dp_cmd.op == OP_OUT), "spurious result")

endmodule
